// ===== hdl/lbdc_pkg.sv =====
// Shared types and constants for the label/depth contour classifier.
package lbdc_pkg;

    // Default grid limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Field widths
    localparam int LABEL_W   = 7;
    localparam int DEPTH_W   = 24;
    localparam int POS_W     = 10;
    localparam int SIZE_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 56;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_THRESH = 2'd2;

    // Configuration reset values (threshold is 0.2 with 8 fraction bits)
    localparam logic [SIZE_W-1:0]    FRAME_WIDTH_RST  = 11'd640;
    localparam logic [SIZE_W-1:0]    FRAME_HEIGHT_RST = 11'd480;
    localparam logic [DEPTH_W-1:0]   DEPTH_THRESH_RST = 24'd51;

    // One grid corner as stored in the row memory
    typedef struct packed {
        logic               tangent;
        logic [DEPTH_W-1:0] depth;
        logic [LABEL_W-1:0] label;
    } t_corner;

    // Window summary handed from the front stage to the decision stage
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic               tangent0;
        logic               all_eq;
        logic [LABEL_W-1:0] lab0;
        logic [LABEL_W-1:0] relabel;
        logic [DEPTH_W-1:0] dep0;
        logic [DEPTH_W-1:0] diff1;
        logic [DEPTH_W-1:0] diff2;
        logic [DEPTH_W-1:0] diff3;
    } t_win;

endpackage

// ===== hdl/label_depth_contour_classifier.sv =====
// Top level: configuration, front stage and contour decision with output register.
//
//  channel   dir  handshake                     content
//  s_axis    in   i_s_axis_tvalid/o_..tready    one grid corner per transfer
//  m_axis    out  o_m_axis_tvalid/i_..tready    one classified pixel per transfer
//  cfg       in   i_cfg_we                      register index and write data
//
// One corner per cycle is taken unless the output stalls; a pixel passes the window register, then the output register.
// The row memory read is prefetched at the next column address.
// Both pipeline stages advance together whenever the output register is free.
// Reset clears position, left and upper-left corners and valid flags; the row memory keeps
// its contents and row zero never produces a pixel.
module label_depth_contour_classifier
    import lbdc_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // corner stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_DATA_W-1:0]  i_s_axis_tdata,  // corner_label, corner_depth, corner_tangent
    // pixel stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_DATA_W-1:0]  o_m_axis_tdata,  // pixel_row, pixel_col, is_contour,
                                                  // is_foreground, pixel_label, pixel_depth, pad
    output logic                 o_m_axis_tlast   // last_of_frame
);

    localparam int COL_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
    localparam int WCMP  = (COL_W > SIZE_W) ? COL_W : SIZE_W;
    localparam int HCMP  = (ROW_W > SIZE_W) ? ROW_W : SIZE_W;
    localparam int PAD_W = M_DATA_W - (2 * POS_W + 2 + LABEL_W + DEPTH_W);

    logic [SIZE_W-1:0]  r_frame_width, r_frame_height;
    logic [DEPTH_W-1:0] r_depth_thresh;
    logic [COL_W-1:0]   w_eff;
    logic [ROW_W-1:0]   h_eff;

    logic    accept, advance;
    t_corner corner;
    t_win    win;

    logic [DEPTH_W-1:0] max12, max_diff;
    logic               depth_edge, contour, fg;
    logic [LABEL_W-1:0] label;
    logic [DEPTH_W-1:0] depth;

    logic                r_m_valid, r_m_last;
    logic [M_DATA_W-1:0] r_m_data;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_depth_thresh <= DEPTH_THRESH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[SIZE_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[SIZE_W-1:0];
                REG_DEPTH_THRESH: r_depth_thresh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp frame size into 1..MAX
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = COL_W'(1);
        end else if (WCMP'(r_frame_width) > WCMP'(MAX_WIDTH)) begin
            w_eff = COL_W'(MAX_WIDTH);
        end else begin
            w_eff = COL_W'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_eff = ROW_W'(1);
        end else if (HCMP'(r_frame_height) > HCMP'(MAX_HEIGHT)) begin
            h_eff = ROW_W'(MAX_HEIGHT);
        end else begin
            h_eff = ROW_W'(r_frame_height);
        end
    end

    // Handshake: stall all stages only while the output register holds
    assign advance         = !r_m_valid || i_m_axis_tready;
    assign o_s_axis_tready = advance;
    assign accept          = i_s_axis_tvalid && advance;

    assign corner.label   = i_s_axis_tdata[LABEL_W-1:0];
    assign corner.depth   = i_s_axis_tdata[LABEL_W +: DEPTH_W];
    assign corner.tangent = i_s_axis_tdata[LABEL_W + DEPTH_W];

    lbdc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_advance (advance),
        .i_corner  (corner),
        .i_w       (w_eff),
        .i_h       (h_eff),
        .o_win     (win)
    );

    // Decide contour, foreground, label and depth
    always_comb begin
        max12      = (win.diff1 > win.diff2) ? win.diff1 : win.diff2;
        max_diff   = (max12 > win.diff3) ? max12 : win.diff3;
        depth_edge = !win.tangent0 && !win.all_eq && (max_diff > r_depth_thresh);
        contour    = win.tangent0 || depth_edge;
        fg         = win.tangent0 || !win.all_eq || !win.lab0[LABEL_W-1];
        label      = depth_edge ? win.relabel : win.lab0;
        depth      = fg ? win.dep0 : '0;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (advance) begin
            r_m_valid <= win.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_m_last <= win.last;
            r_m_data <= {PAD_W'(0), depth, label, fg, contour, win.col, win.row};
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tlast  = r_m_last;

endmodule

// ===== hdl/lbdc_front.sv =====
// Grid position counters, previous-row memory and 2x2 window front stage.
module lbdc_front
    import lbdc_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    localparam int COL_W = $clog2(MAX_WIDTH + 1),
    localparam int ROW_W = $clog2(MAX_HEIGHT + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_advance,
    input  t_corner          i_corner,
    input  logic [COL_W-1:0] i_w,
    input  logic [ROW_W-1:0] i_h,
    output t_win             o_win
);

    // Previous grid row, one corner per column
    t_corner r_row_mem [0:MAX_WIDTH];
    t_corner r_above;

    t_corner r_left, r_upper_left;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] rd_addr;
    t_win r_win, n_win;

    logic [LABEL_W-1:0] labs [4];
    logic [DEPTH_W-1:0] deps [4];
    logic [LABEL_W-1:0] last_nonneg;
    logic               emit;
    logic [ROW_W-1:0]   row_m1;
    logic [COL_W-1:0]   col_m1;

    // Step the raster position, wrapping at the clamped frame size
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if (r_col >= i_w) begin
                n_col = '0;
                n_row = (r_row >= i_h) ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    // Prefetch the entry above the next corner
    assign rd_addr = n_col;

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_row_mem[r_col] <= i_corner;
        end
        r_above <= r_row_mem[rd_addr];
    end

    // Position and neighbor corners
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_left       <= '0;
            r_upper_left <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_accept) begin
                r_left       <= i_corner;
                r_upper_left <= r_above;
            end
        end
    end

    // Summarize the window: labels, depth differences, position
    always_comb begin
        labs[0] = r_upper_left.label;
        labs[1] = r_left.label;
        labs[2] = r_above.label;
        labs[3] = i_corner.label;
        deps[0] = r_upper_left.depth;
        deps[1] = r_left.depth;
        deps[2] = r_above.depth;
        deps[3] = i_corner.depth;

        last_nonneg = '1;
        for (int q = 0; q < 4; q++) begin
            if (!labs[q][LABEL_W-1]) begin
                last_nonneg = labs[q];
            end
        end

        emit   = (r_row != '0) && (r_col != '0) && (r_row <= i_h) && (r_col <= i_w);
        row_m1 = r_row - 1'b1;
        col_m1 = r_col - 1'b1;

        n_win.valid    = i_accept && emit;
        n_win.last     = (r_row == i_h) && (r_col == i_w);
        n_win.row      = POS_W'(row_m1);
        n_win.col      = POS_W'(col_m1);
        n_win.tangent0 = r_upper_left.tangent;
        n_win.all_eq   = (labs[0] == labs[1]) && (labs[1] == labs[2]) && (labs[2] == labs[3]);
        n_win.lab0     = labs[0];
        n_win.relabel  = last_nonneg;
        n_win.dep0     = deps[0];
        n_win.diff1    = (deps[1] > deps[0]) ? deps[1] - deps[0] : deps[0] - deps[1];
        n_win.diff2    = (deps[2] > deps[0]) ? deps[2] - deps[0] : deps[0] - deps[2];
        n_win.diff3    = (deps[3] > deps[0]) ? deps[3] - deps[0] : deps[0] - deps[3];
    end

    // Hold the summary while the output side stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.valid <= 1'b0;
        end else if (i_advance) begin
            r_win <= n_win;
        end
    end

    assign o_win = r_win;

endmodule
